// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL of the queue unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RRQE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrqe assertion failed");

// Check a property on every rising clock edge, reset included.
`define RRQE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rrqe assertion failed");

`endif

// ----- rtl/rrqe_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rrqe_pkg
// Types, constants and helpers shared by the queue controller and datapath.
// ============================================================================
package rrqe_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int ID_W        = 30;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [ID_W-1:0]  DEPTH_ID  = ID_W'(QUEUE_DEPTH);

    localparam logic [1:0] REQ_NEXT     = 2'd0;
    localparam logic [1:0] REQ_EXPEDITE = 2'd1;
    localparam logic [1:0] REQ_RELOAD   = 2'd2;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] target_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] served_id;
        logic            empty_flag;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT_WR,
        S_RELOAD,
        S_EXP_SCAN,
        S_EXP_TAIL
    } t_state;

    typedef struct packed {
        logic emit_empty;
        logic rd_front;
        logic next_commit;
        logic reload_start;
        logic reload_step;
        logic exp_start;
        logic exp_scan;
        logic exp_tail;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic id_zero;
        logic pop_zero;
        logic reload_last;
        logic scan_hit;
        logic scan_last;
    } t_dp_sts;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/rrqe_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ============================================================================
// rrqe_ctrl
// Sequencer for next, expedite and reload items; drives the datapath.
// ============================================================================
module rrqe_ctrl
    import rrqe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req_type)
                        REQ_NEXT: begin
                            if (i_sts.count_zero) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                o_cmd.rd_front = 1'b1;
                                n_state        = S_NEXT_WR;
                            end
                        end
                        REQ_EXPEDITE: begin
                            if (!i_sts.id_zero) begin
                                o_cmd.exp_start = 1'b1;
                                n_state = i_sts.count_zero ? S_EXP_TAIL : S_EXP_SCAN;
                            end
                        end
                        REQ_RELOAD: begin
                            o_cmd.reload_start = 1'b1;
                            if (!i_sts.pop_zero) begin
                                n_state = S_RELOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_NEXT_WR: begin
                o_cmd.next_commit = 1'b1;
                n_state           = S_IDLE;
            end
            S_RELOAD: begin
                o_cmd.reload_step = 1'b1;
                if (i_sts.reload_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EXP_SCAN: begin
                o_cmd.exp_scan = 1'b1;
                priority if (i_sts.scan_hit) begin
                    n_state = S_IDLE;
                end else if (i_sts.scan_last) begin
                    n_state = S_EXP_TAIL;
                end
            end
            S_EXP_TAIL: begin
                o_cmd.exp_tail = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `RRQE_ASSERT(a_next_from_idle, i_clk, i_rst_n, (r_state == S_NEXT_WR) |-> ($past(r_state) == S_IDLE))
    `RRQE_ASSERT(a_tail_returns, i_clk, i_rst_n, (r_state == S_EXP_TAIL) |=> (r_state == S_IDLE))

endmodule

// ----- rtl/rrqe_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ============================================================================
// rrqe_dp
// Order store, head and count registers, scan carry and result register.
// ============================================================================
module rrqe_dp
    import rrqe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_req            i_req,
    input  logic            i_cfg_we,
    input  logic [ID_W-1:0] i_cfg_wdata,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts,
    output logic            o_done,
    output t_rsp            o_rsp
);

    logic [ID_W-1:0]   r_order [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_rdata;
    logic [ADDR_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_pop;
    logic [ID_W-1:0]   r_id,    n_id;
    logic [ID_W-1:0]   r_prev,  n_prev;
    logic [CNT_W-1:0]  r_off,   n_off;
    logic [CNT_W-1:0]  r_woff,  n_woff;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_rsp,   n_rsp;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  load_cnt;

    assign load_cnt = (r_pop > DEPTH_ID) ? DEPTH_CNT : r_pop[CNT_W-1:0];
    assign rd_addr  = i_cmd.exp_scan ? slot_of(r_head, r_off) : r_head;

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_id        = r_id;
        n_prev      = r_prev;
        n_off       = r_off;
        n_woff      = r_woff;
        n_out_valid = 1'b0;
        n_rsp       = r_rsp;
        wr_en       = 1'b0;
        wr_addr     = slot_of(r_head, r_count);
        wr_data     = r_prev;
        if (i_cmd.emit_empty) begin
            n_out_valid      = 1'b1;
            n_rsp.served_id  = '0;
            n_rsp.empty_flag = 1'b1;
        end
        if (i_cmd.next_commit) begin
            wr_en            = 1'b1;
            wr_data          = r_rdata;
            n_head           = slot_of(r_head, CNT_W'(1));
            n_out_valid      = 1'b1;
            n_rsp.served_id  = r_rdata;
            n_rsp.empty_flag = 1'b0;
        end
        if (i_cmd.reload_start) begin
            n_head  = '0;
            n_count = load_cnt;
            n_off   = '0;
        end
        if (i_cmd.reload_step) begin
            wr_en   = 1'b1;
            wr_addr = r_off[ADDR_W-1:0];
            wr_data = ID_W'(r_off) + ID_W'(1);
            n_off   = r_off + CNT_W'(1);
        end
        if (i_cmd.exp_start) begin
            n_id   = i_req.target_id;
            n_prev = i_req.target_id;
            n_woff = '0;
            n_off  = CNT_W'(1);
        end
        if (i_cmd.exp_scan) begin
            wr_en   = 1'b1;
            wr_addr = slot_of(r_head, r_woff);
            wr_data = r_prev;
            n_prev  = r_rdata;
            n_woff  = r_woff + CNT_W'(1);
            n_off   = r_off + CNT_W'(1);
        end
        if (i_cmd.exp_tail && (r_count != DEPTH_CNT)) begin
            wr_en   = 1'b1;
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_order[wr_addr] <= wr_data;
        end
        r_rdata <= r_order[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pop       <= ID_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pop <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prev <= n_prev;
        r_off  <= n_off;
        r_woff <= n_woff;
        r_rsp  <= n_rsp;
    end

    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.id_zero     = (i_req.target_id == '0);
    assign o_sts.pop_zero    = (r_pop == '0);
    assign o_sts.reload_last = ((r_off + CNT_W'(1)) == r_count);
    assign o_sts.scan_hit    = (r_rdata == r_id);
    assign o_sts.scan_last   = ((r_woff + CNT_W'(1)) == r_count);

    assign o_done = r_out_valid;
    assign o_rsp  = r_rsp;

    `RRQE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_CNT)
    `RRQE_ASSERT(a_head_bound, i_clk, i_rst_n, (CNT_W'(r_head) < DEPTH_CNT))

endmodule

// ----- rtl/round_robin_queue_with_expedite_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// round_robin_queue_with_expedite_unit
// Circular service order of identifiers with serve, expedite and reload.
// ============================================================================
// An item is taken when i_start is high and o_busy is low. A next item
// returns its result on o_rsp with o_done high for exactly one cycle; the
// receiver must take it then. A next item reads the front entry, writes it
// back at the tail and advances the head; on an empty queue it answers with
// the empty flag only. A reload writes identifiers 1 to min(population,
// 1024) in order. An expedite moves the identifier to the head and shifts
// the entries before it back. The order store gives one registered read and
// one write per cycle, so a scan and rewrite moves one entry per cycle.
module round_robin_queue_with_expedite_unit
    import rrqe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  t_req            i_req,
    output logic            o_done,
    output t_rsp            o_rsp,
    input  logic            i_cfg_we,
    input  logic [ID_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rrqe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (o_busy)
    );

    rrqe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule
